@@ design/skm_pkg.sv @@
// Package for the sorted key matcher: sizes, command codes and transaction types.
// Shared by skm_cell, sorted_key_match_binary_search and the testbench; no dependencies.
package skm_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int QPOS_W      = 20;
  localparam int MPOS_W      = 10;
  // The open window spans depth+1 and each probe leaves at most half of it rounded up,
  // so ADDR_W+1 probes always finish a search.
  localparam int NUM_CELLS   = ADDR_W + 1;

  localparam logic [QPOS_W-1:0] QCOUNT_MAX = {QPOS_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RESTART = 2'd2
  } skm_cmd_e;

  typedef struct packed {
    skm_cmd_e                 cmd;
    logic signed [KEY_W-1:0]  key;
  } skm_in_t;

  typedef struct packed {
    logic [QPOS_W-1:0] query_position;
    logic [MPOS_W-1:0] match_position;
  } skm_out_t;

  // Search window travels as lo+1 and hi, so both stay unsigned.
  typedef struct packed {
    logic [CNT_W-1:0]         lo_p1;
    logic [CNT_W-1:0]         hi;
    logic signed [KEY_W-1:0]  key;
    logic [QPOS_W-1:0]        qpos;
    logic                     found;
    logic [ADDR_W-1:0]        where;
  } skm_probe_t;

endpackage

@@ design/skm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/skm_cell.sv @@
// One binary search step: a table copy, one probe per cycle, window handed onward.
// Depends on skm_pkg and skm_ram.
module skm_cell import skm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [KEY_W-1:0]  wr_key_i,
  input  logic              valid_i,
  input  skm_probe_t        probe_i,
  output logic              valid_o,
  output skm_probe_t        probe_o
);

  logic [CNT_W:0]    sum;
  logic [CNT_W:0]    mid_full;
  logic [ADDR_W-1:0] mid_d, mid_q;
  logic              valid_q;
  skm_probe_t        probe_q;
  logic [KEY_W-1:0]  entry;
  logic              live;

  // Probe address from the incoming window; garbage when the window is closed.
  assign sum      = {1'b0, probe_i.lo_p1} + {1'b0, probe_i.hi};
  assign mid_full = (sum - (CNT_W+1)'(1)) >> 1;
  assign mid_d    = mid_full[ADDR_W-1:0];

  skm_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_key_i),
    .raddr_i (mid_d),
    .rdata_o (entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_i;
    mid_q   <= mid_d;
  end

  assign live = !probe_q.found && (probe_q.hi > probe_q.lo_p1);

  always_comb begin
    probe_o = probe_q;
    if (live) begin
      if ($signed(entry) > probe_q.key) begin
        probe_o.hi = CNT_W'(mid_q);
      end else if ($signed(entry) < probe_q.key) begin
        probe_o.lo_p1 = CNT_W'(mid_q) + CNT_W'(1);
      end else begin
        probe_o.found = 1'b1;
        probe_o.where = mid_q;
      end
    end
  end

  assign valid_o = valid_q;

endmodule

@@ design/sorted_key_match_binary_search.sv @@
// Sorted key matcher: load an ascending key table, then look up query keys by binary search.
// Depends on skm_pkg and skm_cell (which holds skm_ram).
//
// Load and restart transactions complete in the cycle they are accepted and keep busy low.
// A query raises busy after its accept and keeps it high while it walks a chain of NUM_CELLS
// search cells (log2 of the depth plus one probes), one probe per cell per cycle, each cell
// reading its own copy of the table. On a match the result strobe fires for one cycle, the
// first cycle with busy low again; no match or an empty table gives no strobe. The receiver
// cannot stall, so results are never held.
// Table entries need no clearing after reset: only entries loaded since the last restart
// are ever probed.
module sorted_key_match_binary_search import skm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  skm_in_t  item_i,
  output logic     result_stb_o,
  output skm_out_t result_o
);

  logic                  accept;
  logic                  launch;
  logic                  wr_en;
  logic [CNT_W-1:0]      table_count_d, table_count_q;
  logic [QPOS_W-1:0]     query_count_d, query_count_q;
  logic [NUM_CELLS:0]    valid_chain;
  skm_probe_t            probe_chain [NUM_CELLS+1];
  logic                  res_stb_q;
  skm_out_t              res_q;

  assign accept = start && !busy;
  assign launch = accept && (item_i.cmd == CMD_QUERY);
  assign wr_en  = accept && (item_i.cmd == CMD_LOAD)
                  && (table_count_q < CNT_W'(TABLE_DEPTH));

  always_comb begin
    table_count_d = table_count_q;
    query_count_d = query_count_q;
    if (accept) begin
      unique case (item_i.cmd)
        CMD_LOAD: begin
          if (wr_en) begin
            table_count_d = table_count_q + CNT_W'(1);
          end
        end
        CMD_QUERY: begin
          if (query_count_q != QCOUNT_MAX) begin
            query_count_d = query_count_q + QPOS_W'(1);
          end
        end
        CMD_RESTART: begin
          table_count_d = '0;
          query_count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_count_q <= '0;
      query_count_q <= '0;
    end else begin
      table_count_q <= table_count_d;
      query_count_q <= query_count_d;
    end
  end

  // Open window is lo = -1, hi = table count.
  always_comb begin
    probe_chain[0].lo_p1 = '0;
    probe_chain[0].hi    = table_count_q;
    probe_chain[0].key   = item_i.key;
    probe_chain[0].qpos  = query_count_q;
    probe_chain[0].found = 1'b0;
    probe_chain[0].where = '0;
  end
  assign valid_chain[0] = launch;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    skm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .wr_addr_i (table_count_q[ADDR_W-1:0]),
      .wr_key_i  (item_i.key),
      .valid_i   (valid_chain[i]),
      .probe_i   (probe_chain[i]),
      .valid_o   (valid_chain[i+1]),
      .probe_o   (probe_chain[i+1])
    );
  end

  assign busy = |valid_chain[NUM_CELLS:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stb_q <= 1'b0;
    end else begin
      res_stb_q <= valid_chain[NUM_CELLS] && probe_chain[NUM_CELLS].found;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.query_position <= probe_chain[NUM_CELLS].qpos;
    res_q.match_position <= MPOS_W'(probe_chain[NUM_CELLS].where);
  end

  assign result_stb_o = res_stb_q;
  assign result_o     = res_q;

  a_stb_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_stb_o |-> $past(busy))
    else $error("result strobe without a query in flight");

  a_empty_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (launch && (table_count_q == '0)) |-> ##(NUM_CELLS+1) !result_stb_o)
    else $error("result from a query on an empty table");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    table_count_q <= CNT_W'(TABLE_DEPTH))
    else $error("table count beyond depth");

endmodule

@@ tb/sv/sorted_key_match_binary_search_tb.sv @@
// Testbench for sorted_key_match_binary_search: directed table, then random load/query sessions.
// Checks results against a built-in binary search over a shadow key table, or typed values for directed rows.
// Depends on skm_pkg and the sorted_key_match_binary_search RTL.
module sorted_key_match_binary_search_tb;
  import skm_pkg::*;

  typedef enum logic [1:0] {
    EXP_FROM_MODEL,
    EXP_NONE,
    EXP_MATCH
  } exp_src_e;

  typedef struct {
    skm_in_t  item;
    exp_src_e src;
    skm_out_t typed;
  } dir_row_t;

  localparam int ITEM_TARGET = 1600;
  localparam int FULL_SESSION = 4;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  skm_in_t  item_i;
  logic     result_stb_o;
  skm_out_t result_o;

  // shadow state of the block
  logic signed [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  int unsigned             shadow_count;
  logic [QPOS_W-1:0]       shadow_qcount;
  skm_out_t                pending_matches[$];

  dir_row_t directed_rows[$];
  int       burst_left;
  int       n_errors, n_items, n_loads, n_dropped, n_queries, n_hits, n_restarts, n_ignored;

  sorted_key_match_binary_search u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .result_stb_o (result_stb_o),
    .result_o     (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("timeout: %0d matches still pending", pending_matches.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    n_errors++;
  endtask

  function automatic skm_in_t mk_item(input skm_cmd_e cmd, input logic [KEY_W-1:0] key);
    skm_in_t it;
    it.cmd = cmd;
    it.key = key;
    return it;
  endfunction

  function automatic dir_row_t row(input skm_cmd_e cmd, input logic [KEY_W-1:0] key,
                                   input exp_src_e src, input int qp = 0, input int mp = 0);
    dir_row_t r;
    r.item = mk_item(cmd, key);
    r.src = src;
    r.typed.query_position = QPOS_W'(qp);
    r.typed.match_position = MPOS_W'(mp);
    return r;
  endfunction

  // Probe sequence of the block: window (lo, hi), stop on equal or when it closes.
  function automatic bit search_table(input logic signed [KEY_W-1:0] key, output int pos);
    int lo, hi, mid;
    lo = -1;
    hi = shadow_count;
    pos = 0;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (shadow_keys[mid] > key) begin
        hi = mid;
      end else if (shadow_keys[mid] < key) begin
        lo = mid;
      end else begin
        pos = mid;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_lookup(input skm_in_t it, output bit hit, output skm_out_t res);
    int pos;
    hit = 1'b0;
    res = '0;
    case (it.cmd)
      CMD_LOAD: begin
        n_loads++;
        if (shadow_count < TABLE_DEPTH) begin
          shadow_keys[shadow_count] = it.key;
          shadow_count++;
        end else begin
          n_dropped++;
        end
      end
      CMD_RESTART: begin
        n_restarts++;
        shadow_count = 0;
        shadow_qcount = '0;
      end
      CMD_QUERY: begin
        n_queries++;
        res.query_position = shadow_qcount;
        if (shadow_qcount != QCOUNT_MAX) shadow_qcount++;
        if (shadow_count != 0 && search_table(it.key, pos)) begin
          hit = 1'b1;
          res.match_position = MPOS_W'(pos);
          n_hits++;
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  // Hold start until the block takes the transaction, then record what it should produce.
  task automatic send_item(input skm_in_t it, input exp_src_e src, input skm_out_t typed);
    bit       hit;
    skm_out_t res;
    if (burst_left == 0) begin
      start <= 1'b0;
      item_i <= skm_in_t'({2'($urandom_range(0, 3)), $urandom()});
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 25);
    end
    burst_left--;
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_lookup(it, hit, res);
    if (it.cmd != CMD_LOAD && it.cmd != CMD_QUERY && it.cmd != CMD_RESTART) begin
      return;
    end
    n_items++;
    if (src == EXP_FROM_MODEL && hit) pending_matches.push_back(res);
    else if (src == EXP_MATCH) pending_matches.push_back(typed);
  endtask

  task automatic send(input skm_in_t it);
    send_item(it, EXP_FROM_MODEL, '0);
  endtask

  // One session: restart, load a table, then run queries, with some noise mixed into both.
  task automatic run_session(input int n_keys, input bit ascending, input bit narrow);
    logic [KEY_W-1:0] keys[$];
    longint           cur;
    int unsigned      step_max;
    int               n_q, r, nk;
    logic [KEY_W-1:0] qkey;
    send(mk_item(CMD_RESTART, $urandom()));
    if (narrow) begin
      cur = longint'($signed($urandom()));
      if (cur > 64'sd2147483647 - 4 * longint'(n_keys)) cur -= 4 * longint'(n_keys) + 4;
    end else begin
      cur = -64'sd2147483648;
    end
    step_max = 32'hFFFF_FFFF / (n_keys + 1);
    for (int i = 0; i < n_keys; i++) begin
      if (!ascending) begin
        keys.push_back(($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 63));
      end else begin
        cur += narrow ? longint'($urandom_range(0, 3)) : longint'($urandom_range(0, step_max));
        keys.push_back(cur[KEY_W-1:0]);
      end
      if ($urandom_range(0, 29) == 0) send(mk_item(skm_cmd_e'(2'd3), $urandom()));
      send(mk_item(CMD_LOAD, keys[i]));
    end
    nk = (n_keys < TABLE_DEPTH) ? n_keys : TABLE_DEPTH;
    n_q = $urandom_range(5, 40);
    for (int q = 0; q < n_q; q++) begin
      r = $urandom_range(0, 19);
      if (q == 0 && nk > 0) begin
        // the last entry sits at the deepest probe of the search
        qkey = keys[nk - 1];
      end else if (r < 12 && nk > 0) begin
        qkey = keys[$urandom_range(0, nk - 1)];
      end else if (r < 15 && nk > 0) begin
        qkey = keys[$urandom_range(0, nk - 1)] + (($urandom_range(0, 1) != 0) ? 1 : -1);
      end else if (r == 19) begin
        qkey = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        qkey = $urandom();
      end
      r = $urandom_range(0, 49);
      // break the sequence now and then: append a stray key or an unknown command
      if (r == 0) send(mk_item(CMD_LOAD, $urandom()));
      else if (r == 1) send(mk_item(skm_cmd_e'(2'd3), qkey));
      send(mk_item(CMD_QUERY, qkey));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    skm_out_t want;
    if (rst_ni && result_stb_o) begin
      if (pending_matches.size() == 0) begin
        report_mismatch("result with no match pending, query_position",
                        result_o.query_position, -1);
      end else begin
        want = pending_matches.pop_front();
        if (result_o.query_position !== want.query_position)
          report_mismatch("query_position", result_o.query_position, want.query_position);
        if (result_o.match_position !== want.match_position)
          report_mismatch("match_position", result_o.match_position, want.match_position);
      end
    end
  end

  initial begin : stimulus
    int sess, nk, drain;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    shadow_count = 0;
    shadow_qcount = '0;
    burst_left = 0;

    // table [min, -1, 0, 7, 7, 7, max]
    directed_rows.push_back(row(CMD_QUERY,   32'd5,         EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'h8000_0000, EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'hFFFF_FFFF, EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'd0,         EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'd7,         EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'd7,         EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'd7,         EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'h7FFF_FFFF, EXP_NONE));
    directed_rows.push_back(row(CMD_QUERY,   32'h8000_0000, EXP_MATCH, 1, 0));
    directed_rows.push_back(row(CMD_QUERY,   32'h7FFF_FFFF, EXP_MATCH, 2, 6));
    directed_rows.push_back(row(CMD_QUERY,   32'd7,         EXP_MATCH, 3, 3));
    directed_rows.push_back(row(CMD_QUERY,   32'd3,         EXP_FROM_MODEL));
    directed_rows.push_back(row(skm_cmd_e'(2'd3), 32'd0,    EXP_NONE));
    directed_rows.push_back(row(CMD_QUERY,   32'd0,         EXP_FROM_MODEL));
    directed_rows.push_back(row(CMD_QUERY,   32'hFFFF_FFFF, EXP_FROM_MODEL));
    directed_rows.push_back(row(CMD_RESTART, 32'd0,         EXP_NONE));
    directed_rows.push_back(row(CMD_QUERY,   32'hFFFF_FFFF, EXP_NONE));
    // unsorted table [50, 10, 30, 20]
    directed_rows.push_back(row(CMD_LOAD,    32'd50,        EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'd10,        EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'd30,        EXP_NONE));
    directed_rows.push_back(row(CMD_LOAD,    32'd20,        EXP_NONE));
    directed_rows.push_back(row(CMD_QUERY,   32'd10,        EXP_FROM_MODEL));
    directed_rows.push_back(row(CMD_QUERY,   32'd50,        EXP_FROM_MODEL));
    directed_rows.push_back(row(CMD_QUERY,   32'd20,        EXP_FROM_MODEL));
    directed_rows.push_back(row(CMD_RESTART, 32'hFFFF_FFFF, EXP_NONE));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].src, directed_rows[i].typed);

    sess = 0;
    while (n_items < ITEM_TARGET) begin
      sess++;
      if (sess == FULL_SESSION) begin
        // fill the table and push a few loads past the end
        run_session(TABLE_DEPTH + 4, 1'b1, 1'b0);
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: nk = 0;
          3, 4:    nk = 1;
          5, 6:    nk = 2;
          default: nk = $urandom_range(3, 48);
        endcase
        run_session(nk, $urandom_range(0, 6) != 0, $urandom_range(0, 2) == 0);
      end
    end
    start <= 1'b0;

    drain = 0;
    while (pending_matches.size() != 0 && drain < 100) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (NUM_CELLS + 4) @(posedge clk_i);
    while (pending_matches.size() != 0) begin
      report_mismatch("match never reported, query_position", -1,
                      pending_matches[0].query_position);
      void'(pending_matches.pop_front());
    end

    $display("Covered %0d sessions: %0d loads (%0d dropped on a full table), %0d restarts,",
             sess, n_loads, n_dropped, n_restarts);
    $display("%0d queries with %0d matches, %0d unknown commands; %0d mismatches.",
             n_queries, n_hits, n_ignored, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
